/* src/cbim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_pkg
// Shared types and constants for the correlator baseline index map pipeline.
// ----------------------------------------------------------------------------
package cbim_pkg;

  localparam int STATION_W           = 9;
  localparam int INPUT_W             = 9;
  localparam int INDEX_W             = 19;
  localparam int MAX_STATIONS_DEF    = 256;
  localparam logic [STATION_W-1:0] STATION_COUNT_RESET = 9'd32;

  // Region of the triangular channel order that a pair falls into
  typedef enum logic [1:0] {
    REG_TOP  = 2'd0,
    REG_RECT = 2'd1,
    REG_BOT  = 2'd2
  } region_t;

  // Decode stage result
  typedef struct packed {
    region_t            region;
    logic signed [9:0]  tri_i;
    logic signed [9:0]  tri_j;
    logic signed [9:0]  rect_a;
    logic [7:0]         h;
    logic [8:0]         s;
    logic signed [10:0] h_minus_d;
    logic [6:0]         tile_i;
    logic [6:0]         tile_j;
    logic [1:0]         quad;
    logic [2:0]         tri_lo;
    logic [1:0]         tile_lo;
    logic               ok;
  } dec_t;

  // Multiply stage result
  typedef struct packed {
    region_t            region;
    logic signed [19:0] tri_half;
    logic signed [9:0]  tri_j;
    logic signed [19:0] rect_prod;
    logic [15:0]        tsize;
    logic [7:0]         h;
    logic signed [10:0] h_minus_d;
    logic [15:0]        qsize;
    logic [13:0]        tile_half;
    logic [6:0]         tile_j;
    logic [1:0]         quad;
    logic [2:0]         tri_lo;
    logic [1:0]         tile_lo;
    logic               ok;
  } mul_t;

endpackage

/* src/cbim_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_decode
// First stage: split inputs into station and polarization, pick the region
// and form the multiplier operands.
// ----------------------------------------------------------------------------
module cbim_decode (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cbim_pkg::INPUT_W-1:0]  first_input,
  input  logic [cbim_pkg::INPUT_W-1:0]  second_input,
  input  logic [cbim_pkg::STATION_W-1:0] station_count,
  output cbim_pkg::dec_t                q
);
  import cbim_pkg::*;

  logic [7:0]        a0, a1, h;
  logic              p0, p1;
  logic signed [9:0] d;
  logic signed [9:0] h_s, a0_s, a1_s, s_s;
  dec_t              q_next;

  assign a0   = first_input[8:1];
  assign a1   = second_input[8:1];
  assign p0   = first_input[0];
  assign p1   = second_input[0];
  assign h    = station_count[8:1];
  assign h_s  = $signed({2'b00, h});
  assign a0_s = $signed({2'b00, a0});
  assign a1_s = $signed({2'b00, a1});
  assign s_s  = $signed({1'b0, station_count});
  assign d    = a1_s - a0_s;

  // Select region and triangle operands
  always_comb begin
    q_next        = '0;
    q_next.tri_i  = a1_s;
    q_next.tri_j  = a0_s;
    if (d > h_s) begin
      q_next.region = REG_BOT;
      q_next.tri_i  = h_s - 10'sd2 - a0_s;
      q_next.tri_j  = s_s - 10'sd1 - a1_s;
    end else if (a1 < h) begin
      q_next.region = REG_TOP;
    end else begin
      q_next.region = REG_RECT;
    end
    q_next.rect_a    = a1_s - h_s;
    q_next.h         = h;
    q_next.s         = station_count;
    q_next.h_minus_d = $signed({3'b000, h}) - 11'(d);
    q_next.tile_i    = a1[7:1];
    q_next.tile_j    = a0[7:1];
    q_next.quad      = {a0[0], a1[0]};
    q_next.tri_lo    = {p0 ^ p1, p0, 1'b0};
    q_next.tile_lo   = {p1, p0};
    q_next.ok        = (second_input >= first_input)
                    && ({1'b0, first_input} < {station_count, 1'b0})
                    && ({1'b0, second_input} < {station_count, 1'b0});
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* src/cbim_mult.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_mult
// Second stage: the triangle, rectangle, region size, quadrant size and tile
// products, side by side.
// ----------------------------------------------------------------------------
module cbim_mult (
  input  logic           clk,
  input  logic           en,
  input  cbim_pkg::dec_t d,
  output cbim_pkg::mul_t q
);
  import cbim_pkg::*;

  logic [8:0]         hp1;
  logic signed [20:0] tri_prod;
  logic signed [19:0] rect_prod;
  logic [16:0]        tsize_prod;
  logic [17:0]        qsize_prod;
  logic [14:0]        tile_prod;
  mul_t               q_next;

  assign hp1        = {1'b0, d.h} + 9'd1;
  assign tri_prod   = 21'(d.tri_i) * (21'(d.tri_i) + 21'sd1);
  assign rect_prod  = 20'(d.rect_a) * $signed({11'd0, hp1});
  assign tsize_prod = 17'(d.h) * 17'(hp1);
  assign qsize_prod = 18'(hp1) * 18'(d.s);
  assign tile_prod  = 15'(d.tile_i) * (15'(d.tile_i) + 15'd1);

  // Halve the triangle, region size and tile products, quarter the quadrant size product, pass the rest along
  always_comb begin
    q_next           = '0;
    q_next.region    = d.region;
    q_next.tri_half  = 20'(tri_prod >>> 1);
    q_next.tri_j     = d.tri_j;
    q_next.rect_prod = rect_prod;
    q_next.tsize     = tsize_prod[16:1];
    q_next.h         = d.h;
    q_next.h_minus_d = d.h_minus_d;
    q_next.qsize     = qsize_prod[17:2];
    q_next.tile_half = tile_prod[14:1];
    q_next.tile_j    = d.tile_j;
    q_next.quad      = d.quad;
    q_next.tri_lo    = d.tri_lo;
    q_next.tile_lo   = d.tile_lo;
    q_next.ok        = d.ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* src/cbim_combine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_combine
// Third stage: add up the cell number in each order and scale it to a word
// index, modulo the index width.
// ----------------------------------------------------------------------------
module cbim_combine (
  input  logic                          clk,
  input  logic                          en,
  input  cbim_pkg::mul_t                m,
  output logic [cbim_pkg::INDEX_W-1:0]  triangle_word_index,
  output logic [cbim_pkg::INDEX_W-1:0]  tile_word_index,
  output logic                          pair_ok
);
  import cbim_pkg::*;

  logic [INDEX_W-1:0] tsz, last, tri_pos, slot, quad_off, tile_sum;

  assign tsz     = 19'(m.tsize);
  assign last    = (tsz << 2) - 19'(m.h) - 19'd1;
  assign tri_pos = 19'(m.tri_half) + 19'(m.tri_j);

  // Pick the cell of the region
  always_comb begin
    case (m.region)
      REG_TOP:  slot = tri_pos;
      REG_BOT:  slot = last - tri_pos;
      REG_RECT: slot = tsz + 19'(m.rect_prod) + 19'(m.h_minus_d);
      default:  slot = tri_pos;
    endcase
  end

  // Quadrant offset is quad times the quadrant size
  assign quad_off = (m.quad[1] ? {2'b00, m.qsize, 1'b0} : '0)
                  + (m.quad[0] ? {3'b000, m.qsize} : '0);
  assign tile_sum = quad_off + 19'(m.tile_half) + 19'(m.tile_j);

  always_ff @(posedge clk) begin
    if (en) begin
      triangle_word_index <= {slot[15:0], m.tri_lo};
      tile_word_index     <= {tile_sum[16:0], m.tile_lo};
      pair_ok             <= m.ok;
    end
  end

endmodule

/* src/correlator_baseline_index_map_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// correlator_baseline_index_map_top
// Maps a pair of correlator inputs to real-part word indices in triangular
// channel order and in register-tile order.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, one input pair each.
//   Result items leave on m_tvalid/m_tready/m_tdata/m_tuser; m_tuser is the
//   pair flag (1 when the pair is ordered and within the station count).
//   The station count is written through cfg_wen/cfg_wdata while idle;
//   values above MAX_STATIONS are clamped.
//   An accepted item moves through the decode, multiply and combine stages,
//   each one register deep; m_tvalid rises once it holds the combine
//   register. One item is accepted per cycle while s_tready stays high.
//   Each stage has its own valid bit and takes a new item whenever it is
//   empty or its successor moves, so bubbles close up during a stall.
//   When m_tready is low the output holds; the stages fill up and s_tready
//   drops once all three hold items. Nothing is lost or repeated.
//   Reset empties the pipeline and sets the station count to 32.
// ----------------------------------------------------------------------------
module correlator_baseline_index_map_top #(
  parameter int MAX_STATIONS = cbim_pkg::MAX_STATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [cbim_pkg::STATION_W-1:0] cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [8:0] first_input, [17:9] second_input, [23:18] zero
  input  logic [23:0]                   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [18:0] triangle_word_index, [37:19] tile_word_index, [39:38] zero
  output logic [39:0]                   m_tdata,
  // [0] pair_ok
  output logic                          m_tuser
);
  import cbim_pkg::*;

  logic [STATION_W-1:0] station_count;
  logic                 v1, v2, v3;
  logic                 rdy1, rdy2, rdy3;
  dec_t                 dec_q;
  mul_t                 mul_q;
  logic [INDEX_W-1:0]   tri_idx, tile_idx;
  logic                 ok;

  // Latch station count, clamped to the supported maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      station_count <= STATION_COUNT_RESET;
    end else if (cfg_wen) begin
      if (32'(cfg_wdata) > MAX_STATIONS) begin
        station_count <= STATION_W'(MAX_STATIONS);
      end else begin
        station_count <= cfg_wdata;
      end
    end
  end

  // Advance each stage when it is empty or its successor moves
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  cbim_decode u_decode (
    .clk           (clk),
    .en            (rdy1),
    .first_input   (s_tdata[8:0]),
    .second_input  (s_tdata[17:9]),
    .station_count (station_count),
    .q             (dec_q)
  );

  cbim_mult u_mult (
    .clk (clk),
    .en  (rdy2),
    .d   (dec_q),
    .q   (mul_q)
  );

  cbim_combine u_combine (
    .clk                 (clk),
    .en                  (rdy3),
    .m                   (mul_q),
    .triangle_word_index (tri_idx),
    .tile_word_index     (tile_idx),
    .pair_ok             (ok)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {2'b00, tile_idx, tri_idx};
  assign m_tuser  = ok;

  // Pipeline comes out of reset empty
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // An accepted item occupies the decode stage next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted item lost at decode stage");

  // A stalled multiply stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    (v2 && v3 && !m_tready) |=> v2)
    else $error("item dropped from multiply stage during stall");

  // A multiply stage item reaches the output when the output frees up
  assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> m_tvalid)
    else $error("item lost between multiply and output stage");

  // Station count never exceeds the supported maximum after a write
  assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> (32'(station_count) <= MAX_STATIONS))
    else $error("station count above maximum");

endmodule

/* test/tb_correlator_baseline_index_map_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_correlator_baseline_index_map_top
// Streams input pairs through the baseline index map under several station
// counts, predicts both word indices and the pair flag for every accepted
// item, and compares each result item against the oldest prediction while
// both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_correlator_baseline_index_map_top;

  import cbim_pkg::*;

  localparam int MAX_ST         = MAX_STATIONS_DEF;
  localparam int IDLE_LIMIT     = 4000;
  localparam int ITEMS_PER_STEP = 115;
  localparam int PRINT_CAP      = 40;

  // One predicted result item
  typedef struct {
    logic [INDEX_W-1:0] tri_idx;
    logic [INDEX_W-1:0] tile_idx;
    logic               ok;
  } index_result_t;

  // Predicts the index pair for each accepted input and checks the results
  class baseline_map_checker;
    int unsigned   station;
    index_result_t pending_indices[$];
    int            errors;
    int            checked;
    int            noted;

    function new();
      station = 32'(STATION_COUNT_RESET);
      errors  = 0;
      checked = 0;
      noted   = 0;
    endfunction

    // Saturate the written count the same way the block does
    function void set_station(logic [STATION_W-1:0] value);
      station = (32'(value) > MAX_ST) ? MAX_ST : 32'(value);
    endfunction

    static function longint tri_number(longint i, longint j);
      return (i * (i + 1)) / 2 + j;
    endfunction

    function int pending();
      return pending_indices.size();
    endfunction

    // Work out both word indices and the flag for one accepted pair
    function void note_pair(logic [INPUT_W-1:0] first_in, logic [INPUT_W-1:0] second_in);
      longint s, a0, a1, p0, p1, h, d, tsz, last_slot, slot, tri_word;
      longint quad, qsz, tile_word;
      index_result_t want;
      s  = longint'(station);
      a0 = longint'(first_in >> 1);
      a1 = longint'(second_in >> 1);
      p0 = longint'(first_in[0]);
      p1 = longint'(second_in[0]);
      h  = s / 2;
      d  = a1 - a0;
      tsz = ((h + 1) * h) / 2;
      last_slot = 4 * tsz - h - 1;
      // bottom triangle, top triangle, middle rectangle
      if (d > h)
        slot = last_slot - tri_number(h - 2 - a0, s - 1 - a1);
      else if (a1 < h)
        slot = tri_number(a1, a0);
      else
        slot = tsz + (a1 - h) * (h + 1) + (h - d);
      tri_word = slot * 8 + 2 * (2 * (p0 ^ p1) + p0);
      quad = 2 * (a0 & 1) + (a1 & 1);
      qsz  = ((s / 2 + 1) * s) / 4;
      tile_word = (quad * qsz + tri_number(a1 / 2, a0 / 2)) * 4 + 2 * p1 + p0;
      want.tri_idx  = tri_word[INDEX_W-1:0];
      want.tile_idx = tile_word[INDEX_W-1:0];
      want.ok = (second_in >= first_in) && (longint'(first_in) < 2 * s)
                && (longint'(second_in) < 2 * s);
      pending_indices.push_back(want);
      noted++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP)
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Compare one result item with the oldest prediction
    task check_indices(logic [39:0] data, logic flag);
      index_result_t want;
      if (pending_indices.size() == 0) begin
        report($sformatf("result item with nothing pending, tdata=%h", data));
      end else begin
        want = pending_indices.pop_front();
        checked++;
        if (data[18:0] !== want.tri_idx)
          report($sformatf("triangle index %0d, want %0d", data[18:0], want.tri_idx));
        if (data[37:19] !== want.tile_idx)
          report($sformatf("tile index %0d, want %0d", data[37:19], want.tile_idx));
        if (flag !== want.ok)
          report($sformatf("pair flag %b, want %b", flag, want.ok));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [STATION_W-1:0] cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;
  logic                 m_tuser;

  baseline_map_checker board;
  bit sender_dense;
  bit sink_dense;
  int settings_run;

  correlator_baseline_index_map_top #(
    .MAX_STATIONS(MAX_ST)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one pair and hold it until accepted, then apply a random gap
  task automatic send_pair(input logic [INPUT_W-1:0] first_in,
                           input logic [INPUT_W-1:0] second_in);
    int r;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, second_in, first_in};
    do @(posedge clk); while (!s_tready);
    board.note_pair(first_in, second_in);
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (sender_dense || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Write the station count while the pipeline is empty
  task automatic write_station_count(input logic [STATION_W-1:0] value);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    board.set_station(value);
    settings_run++;
    @(negedge clk);
  endtask

  // Mostly well-formed pairs for the current count, some edges, some noise
  task automatic make_pair(output logic [INPUT_W-1:0] first_in,
                           output logic [INPUT_W-1:0] second_in);
    int lim;
    int r;
    lim = 2 * board.station;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 20) begin
      first_in  = 9'($urandom_range(0, 511));
      second_in = 9'($urandom_range(0, 511));
    end else if (r < 30) begin
      first_in  = $urandom_range(0, 1) ? 9'd0 : 9'(lim - 1);
      second_in = $urandom_range(0, 1) ? 9'(lim - 1) : ((lim < 512) ? 9'(lim) : first_in);
    end else begin
      first_in  = 9'($urandom_range(0, lim - 1));
      second_in = 9'($urandom_range(first_in, lim - 1));
    end
  endtask

  // Receiver ready: runs of ready, short stalls, now and then a long one
  initial begin : sink_ready
    int hold;
    int r;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_dense) begin
        m_tready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_tready <= 1'b1;
          hold = $urandom_range(0, 25);
        end else if (r < 94) begin
          m_tready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          m_tready <= 1'b0;
          hold = $urandom_range(15, 60);
        end
      end
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_indices(m_tdata, m_tuser);
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_correlator_baseline_index_map_top NOT OK");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int dir_first[22] = '{0, 0, 1, 1, 62, 63, 0, 0, 0, 0, 30, 20, 33, 5,
                          64, 0, 511, 0, 510, 511, 2, 3};
    int dir_second[22] = '{0, 1, 1, 0, 63, 63, 63, 40, 32, 31, 31, 41, 62, 3,
                           64, 64, 511, 511, 511, 0, 35, 34};
    int station_plan[9] = '{4, 256, 511, 8, 0, 7, 100, 32, 252};
    logic [INPUT_W-1:0] f;
    logic [INPUT_W-1:0] g;
    board = new();
    settings_run = 1;
    sender_dense = 1'b0;
    sink_dense   = 1'b0;
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pairs at the reset count: each region, flag edges, extremes
    foreach (dir_first[i])
      send_pair(9'(dir_first[i]), 9'(dir_second[i]));

    // Random pairs under a series of station counts
    foreach (station_plan[p]) begin
      write_station_count(9'(station_plan[p]));
      sender_dense = (p == 1 || p == 5);
      sink_dense   = (p == 3 || p == 5);
      for (int n = 0; n < ITEMS_PER_STEP; n++) begin
        if (p == 2 && n == ITEMS_PER_STEP / 2)
          drain_results();
        make_pair(f, g);
        send_pair(f, g);
      end
    end
    sender_dense = 1'b0;
    sink_dense   = 1'b0;

    // Let the last results drain
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Ran %0d input pairs under %0d station counts (clamped, zero and odd ones too);",
             board.noted, settings_run);
    $display("%0d result items checked, %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0)
      $display("tb_correlator_baseline_index_map_top OK");
    else
      $display("tb_correlator_baseline_index_map_top NOT OK");
    $finish;
  end

endmodule
